// ===== hdl/ppl_pkg.sv =====
// ============================================================================
// ppl_pkg: shared types and constants for the lookahead point search
// Beat layouts, state and operation codes, fixed arithmetic widths.
// ============================================================================
`default_nettype none

package ppl_pkg;

    localparam int COORD_W  = 32;
    localparam int DIST_W   = 23;
    localparam int SLOT_IN_W = 3;
    localparam int SEG_W    = 10;
    localparam int FRAC_W   = 27;
    localparam int T_W      = 17;
    localparam int Q_FRAC   = 16;
    localparam int RED_SH   = 4;
    localparam int RED_W    = COORD_W + 1 - RED_SH;
    localparam int RR_W     = DIST_W - RED_SH;
    localparam int OPW      = 60;
    localparam int PW       = 2 * OPW;
    localparam int ACC_W    = 62;
    localparam int ROOT_W   = ACC_W + 1;
    localparam int SQ_ITER  = PW / 2;
    localparam int SQ_CNT_W = $clog2(SQ_ITER + 1);
    localparam int DIV_CNT_W = $clog2(Q_FRAC + 1);
    localparam logic [T_W-1:0] ONE_Q16 = T_W'(1) << Q_FRAC;
    localparam logic [DIST_W-1:0] DIST_RESET = 23'd786432;

    typedef struct packed {
        logic [SLOT_IN_W-1:0]      path_slot;
        logic signed [COORD_W-1:0] robot_x;
        logic signed [COORD_W-1:0] robot_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [SEG_W-1:0]          seg_index;
        logic                      last_segment;
    } seg_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] look_x;
        logic signed [COORD_W-1:0] look_y;
        logic [FRAC_W-1:0]         frac_index;
        logic                      found_new;
    } look_item_t;

    typedef logic [DIST_W-1:0] dist_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SQRT_WAIT,
        ST_DIV,
        ST_FRAC,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_DXDX,
        OP_DYDY,
        OP_DXFX,
        OP_DYFY,
        OP_FXFX,
        OP_FYFY,
        OP_RR,
        OP_HH,
        OP_AC,
        OP_ALX,
        OP_ALY
    } op_t;

endpackage

`default_nettype wire

// ===== hdl/ppl_chan_if.sv =====
// ============================================================================
// ppl_chan_if: valid/ready channel
// One beat moves when valid and ready are both high at a rising edge.
// ============================================================================
`default_nettype none

interface ppl_chan_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/ppl_mul.sv =====
// ============================================================================
// ppl_mul: bit-serial unsigned multiplier
// Retires one multiplier bit per cycle; ends early once no set bits remain.
// ============================================================================
`default_nettype none

module ppl_mul
    import ppl_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [OPW-1:0] op_a,
    input  wire logic [OPW-1:0] op_b,
    output logic                done,
    output logic [PW-1:0]       prod
);

    logic           busy_reg;
    logic [PW-1:0]  mcand_reg;
    logic [OPW-1:0] mplier_reg;
    logic [PW-1:0]  acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (mplier_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= PW'(op_a);
            mplier_reg <= op_b;
            acc_reg    <= '0;
        end
        else if (busy_reg && (mplier_reg != '0))
        begin
            // add the shifted multiplicand for a set bit, then advance
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[OPW-1:1]};
        end
    end

    assign done = busy_reg && (mplier_reg == '0);
    assign prod = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/ppl_isqrt.sv =====
// ============================================================================
// ppl_isqrt: digit-serial integer square root
// Restoring method, one root bit per cycle: floor(sqrt(radicand)).
// ============================================================================
`default_nettype none

module ppl_isqrt
    import ppl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [PW-1:0] radicand,
    output logic               done,
    output logic [OPW-1:0]     root
);

    logic                busy_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [PW-1:0]       rad_reg;
    logic [OPW+3:0]      rem_reg;
    logic [OPW-1:0]      root_reg;
    logic [OPW+3:0]      rem_sh;
    logic [OPW+3:0]      trial;
    logic                ge;

    // bring down the next two radicand bits and try a one in the root
    assign rem_sh = {rem_reg[OPW+1:0], rad_reg[PW-1:PW-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= SQ_CNT_W'(SQ_ITER);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[OPW-2:0], ge};
            rad_reg  <= {rad_reg[PW-3:0], 2'b00};
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/pursuit_lookahead_point_search.sv =====
// Work per segment: none when a hit is already held for the pass; otherwise up to nine
//   products on one bit-serial multiplier (each ends early), a square root, a divide
//   and two more products.
// Throughput: one segment at a time; set by the shared one-bit-per-cycle multiplier.
// Reset: all search state, slot history and the radius register clear at once
//   (radius to 12.0 in Q.16); no clearing pass.
// ============================================================================
// pursuit_lookahead_point_search: pure pursuit lookahead point search
// Intersects each path segment with the lookahead circle around the robot and
// keeps, per pass, the first hit ahead of the slot's previous fractional index.
// ============================================================================
`default_nettype none

module pursuit_lookahead_point_search
    import ppl_pkg::*;
#(
    parameter int PATH_SLOTS   = 5,
    parameter int MAX_SEGMENTS = 1024
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ppl_chan_if.sink    seg_in,
    ppl_chan_if.source  look_out,
    ppl_chan_if.sink    cfg
);

    localparam int SLOT_W = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;

    // ------------------------------------------------------------------
    // Helpers: reduced differences (floor shift by four) and magnitudes
    // ------------------------------------------------------------------
    function automatic logic signed [RED_W-1:0] red_diff(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        logic signed [COORD_W:0] d;
        d = {p[COORD_W-1], p} - {q[COORD_W-1], q};
        return d[COORD_W:RED_SH];
    endfunction

    function automatic logic [OPW-1:0] mag_red(input logic signed [RED_W-1:0] v);
        logic signed [RED_W:0] e;
        logic [RED_W:0]        m;
        e = {v[RED_W-1], v};
        m = e[RED_W] ? -e : e;
        return OPW'(m);
    endfunction

    function automatic logic [OPW-1:0] mag_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? -v : v;
        return m[OPW-1:0];
    endfunction

    function automatic logic [COORD_W:0] full_diff(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q
    );
        return {p[COORD_W-1], p} - {q[COORD_W-1], q};
    endfunction

    function automatic logic [OPW-1:0] mag_full(input logic [COORD_W:0] d);
        logic [COORD_W:0] m;
        m = d[COORD_W] ? -d : d;
        return OPW'(m);
    endfunction

    function automatic op_t next_op(input op_t op);
        op_t r;
        case (op)
            OP_DXDX: r = OP_DYDY;
            OP_DYDY: r = OP_DXFX;
            OP_DXFX: r = OP_DYFY;
            OP_DYFY: r = OP_FXFX;
            OP_FXFX: r = OP_FYFY;
            OP_FYFY: r = OP_RR;
            OP_RR:   r = OP_HH;
            OP_HH:   r = OP_AC;
            OP_AC:   r = OP_ALX;
            OP_ALX:  r = OP_ALY;
            default: r = OP_DXDX;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    dist_t  lookahead_reg;

    // captured segment
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [RED_W-1:0]   dx_reg, dy_reg, fx_reg, fy_reg;
    logic [RR_W-1:0]           rr_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SEG_W-1:0]          seg_reg;
    logic                      last_reg;

    // quadratic terms and root search
    logic [OPW-1:0]            a_reg;
    logic signed [ACC_W-1:0]   h_reg, c_reg;
    logic [PW-1:0]             hh_reg;
    logic [OPW:0]              div_rem_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic [T_W-1:0]            t_reg;

    // hit chosen so far in the pass
    logic                      pass_hit_reg;
    logic signed [COORD_W-1:0] pass_look_x_reg, pass_look_y_reg;
    logic [FRAC_W-1:0]         pass_frac_reg;

    // per-slot history
    logic [FRAC_W-1:0]         prev_frac_reg [PATH_SLOTS];
    logic signed [COORD_W-1:0] prev_x_reg [PATH_SLOTS];
    logic signed [COORD_W-1:0] prev_y_reg [PATH_SLOTS];

    // output stage
    logic                      out_valid_reg;
    look_item_t                out_data_reg;

    // ------------------------------------------------------------------
    // Input capture: saturate slot and index, reduce to Q.12
    // ------------------------------------------------------------------
    seg_item_t          in_beat;
    logic               in_fire;
    logic [SLOT_W-1:0]  slot_sat;
    logic [SEG_W-1:0]   seg_sat;

    assign in_beat      = seg_in.data;
    assign seg_in.ready = (state_reg == ST_IDLE);
    assign in_fire      = seg_in.valid && seg_in.ready;

    always_comb
    begin
        if (32'(in_beat.path_slot) >= 32'(PATH_SLOTS))
        begin
            slot_sat = SLOT_W'(PATH_SLOTS - 1);
        end
        else
        begin
            slot_sat = SLOT_W'(in_beat.path_slot);
        end
        if (32'(in_beat.seg_index) > 32'(MAX_SEGMENTS - 1))
        begin
            seg_sat = SEG_W'(MAX_SEGMENTS - 1);
        end
        else
        begin
            seg_sat = in_beat.seg_index;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand selection by the current operation
    // ------------------------------------------------------------------
    logic           mul_start, mul_done, mul_neg;
    logic [OPW-1:0] mul_a, mul_b;
    logic [PW-1:0]  mul_prod;
    logic [COORD_W:0] dfx, dfy;

    assign dfx = full_diff(ex_reg, sx_reg);
    assign dfy = full_diff(ey_reg, sy_reg);

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (op_reg)
            OP_DXDX:
            begin
                mul_a = mag_red(dx_reg);
                mul_b = mag_red(dx_reg);
            end
            OP_DYDY:
            begin
                mul_a = mag_red(dy_reg);
                mul_b = mag_red(dy_reg);
            end
            OP_DXFX:
            begin
                mul_a   = mag_red(dx_reg);
                mul_b   = mag_red(fx_reg);
                mul_neg = dx_reg[RED_W-1] ^ fx_reg[RED_W-1];
            end
            OP_DYFY:
            begin
                mul_a   = mag_red(dy_reg);
                mul_b   = mag_red(fy_reg);
                mul_neg = dy_reg[RED_W-1] ^ fy_reg[RED_W-1];
            end
            OP_FXFX:
            begin
                mul_a = mag_red(fx_reg);
                mul_b = mag_red(fx_reg);
            end
            OP_FYFY:
            begin
                mul_a = mag_red(fy_reg);
                mul_b = mag_red(fy_reg);
            end
            OP_RR:
            begin
                mul_a = OPW'(rr_reg);
                mul_b = OPW'(rr_reg);
            end
            OP_HH:
            begin
                mul_a = mag_acc(h_reg);
                mul_b = mag_acc(h_reg);
            end
            OP_AC:
            begin
                mul_a = a_reg;
                mul_b = mag_acc(c_reg);
            end
            OP_ALX:
            begin
                mul_a   = mag_full(dfx);
                mul_b   = OPW'(t_reg);
                mul_neg = dfx[COORD_W];
            end
            OP_ALY:
            begin
                mul_a   = mag_full(dfy);
                mul_b   = OPW'(t_reg);
                mul_neg = dfy[COORD_W];
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    ppl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // signed view of the small cross products and of the along-track offset
    logic signed [ACC_W-1:0] prod_s;
    logic signed [63:0]      prod_64;
    logic signed [COORD_W-1:0] along_val;
    logic signed [COORD_W-1:0] along_base;
    logic [OPW-1:0]          a_sum;

    assign prod_s  = mul_neg ? -$signed({2'b00, mul_prod[OPW-1:0]})
                             :  $signed({2'b00, mul_prod[OPW-1:0]});
    assign prod_64 = mul_neg ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
    assign along_base = (op_reg == OP_ALX) ? sx_reg : sy_reg;
    // floor(d*t / 65536) by arithmetic shift, then wrap to 32 bits
    assign along_val  = along_base + prod_64[Q_FRAC+COORD_W-1:Q_FRAC];
    assign a_sum      = a_reg + mul_prod[OPW-1:0];

    // discriminant from h*h and a*|c|
    logic          c_neg, disc_bad;
    logic [PW-1:0] disc;

    assign c_neg    = c_reg[ACC_W-1];
    assign disc_bad = !c_neg && (hh_reg < mul_prod);
    assign disc     = c_neg ? (hh_reg + mul_prod) : (hh_reg - mul_prod);

    // ------------------------------------------------------------------
    // Square root and root selection
    // ------------------------------------------------------------------
    logic           sq_start, sq_done;
    logic [OPW-1:0] sq_root;

    ppl_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (disc),
        .done     (sq_done),
        .root     (sq_root)
    );

    logic signed [ROOT_W-1:0] neg_h, n1, n2, a_ext;
    logic                     n1_ok, n2_ok, root_ok;
    logic [OPW-1:0]           n_pick;

    assign neg_h  = -$signed({h_reg[ACC_W-1], h_reg});
    assign n1     = neg_h - $signed(ROOT_W'(sq_root));
    assign n2     = neg_h + $signed(ROOT_W'(sq_root));
    assign a_ext  = $signed(ROOT_W'(a_reg));
    assign n1_ok  = !n1[ROOT_W-1] && (n1 <= a_ext);
    assign n2_ok  = !n2[ROOT_W-1] && (n2 <= a_ext);
    assign root_ok = n1_ok || n2_ok;
    // smaller root first
    assign n_pick = n1_ok ? n1[OPW-1:0] : n2[OPW-1:0];

    // ------------------------------------------------------------------
    // Fraction: one quotient bit per cycle, then the pass compare
    // ------------------------------------------------------------------
    logic [OPW:0]      div_rem_sh;
    logic              div_ge;
    logic [FRAC_W-1:0] frac_calc;
    logic              frac_gt;

    assign div_rem_sh = {div_rem_reg[OPW-1:0], 1'b0};
    assign div_ge     = div_rem_sh >= {1'b0, a_reg};
    assign frac_calc  = FRAC_W'({seg_reg, {Q_FRAC{1'b0}}}) + FRAC_W'(t_reg);
    assign frac_gt    = frac_calc > prev_frac_reg[slot_reg];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic emit;

    assign emit = (state_reg == ST_FINISH) && last_reg
               && (!out_valid_reg || look_out.ready);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        mul_start  = 1'b0;
        sq_start   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (seg_in.valid)
                begin
                    op_next    = OP_DXDX;
                    // a hit already held for this pass: nothing to search
                    state_next = pass_hit_reg ? ST_FINISH : ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    case (op_reg)
                        OP_DYDY:
                        begin
                            // zero-length segment
                            if (a_sum == '0)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                op_next    = next_op(op_reg);
                                state_next = ST_MUL_GO;
                            end
                        end
                        OP_AC:
                        begin
                            if (disc_bad)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                sq_start   = 1'b1;
                                state_next = ST_SQRT_WAIT;
                            end
                        end
                        OP_ALY:
                        begin
                            state_next = ST_FINISH;
                        end
                        default:
                        begin
                            op_next    = next_op(op_reg);
                            state_next = ST_MUL_GO;
                        end
                    endcase
                end
            end
            ST_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    if (!root_ok)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (n_pick == a_reg)
                    begin
                        state_next = ST_FRAC;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (frac_gt)
                begin
                    op_next    = OP_ALX;
                    state_next = ST_MUL_GO;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg || emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DXDX;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath scratch (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sx_reg   <= in_beat.start_x;
            sy_reg   <= in_beat.start_y;
            ex_reg   <= in_beat.end_x;
            ey_reg   <= in_beat.end_y;
            dx_reg   <= red_diff(in_beat.end_x, in_beat.start_x);
            dy_reg   <= red_diff(in_beat.end_y, in_beat.start_y);
            fx_reg   <= red_diff(in_beat.start_x, in_beat.robot_x);
            fy_reg   <= red_diff(in_beat.start_y, in_beat.robot_y);
            rr_reg   <= lookahead_reg[DIST_W-1:RED_SH];
            slot_reg <= slot_sat;
            seg_reg  <= seg_sat;
            last_reg <= in_beat.last_segment;
        end

        if ((state_reg == ST_MUL_WAIT) && mul_done)
        begin
            case (op_reg)
                OP_DXDX: a_reg  <= mul_prod[OPW-1:0];
                OP_DYDY: a_reg  <= a_sum;
                OP_DXFX: h_reg  <= prod_s;
                OP_DYFY: h_reg  <= h_reg + prod_s;
                OP_FXFX: c_reg  <= prod_s;
                OP_FYFY: c_reg  <= c_reg + prod_s;
                OP_RR:   c_reg  <= c_reg - prod_s;
                OP_HH:   hh_reg <= mul_prod;
                default: hh_reg <= hh_reg;
            endcase
        end

        if ((state_reg == ST_SQRT_WAIT) && sq_done)
        begin
            div_rem_reg <= {1'b0, n_pick};
            div_cnt_reg <= DIV_CNT_W'(Q_FRAC);
            // the end point itself reads as exactly 1.0
            t_reg       <= (n_pick == a_reg) ? ONE_Q16 : '0;
        end
        else if ((state_reg == ST_DIV) && (div_cnt_reg != '0))
        begin
            div_rem_reg <= div_ge ? (div_rem_sh - {1'b0, a_reg}) : div_rem_sh;
            t_reg       <= {t_reg[T_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Radius register, pass state, slot history, output stage
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookahead_reg   <= DIST_RESET;
            pass_hit_reg    <= 1'b0;
            pass_look_x_reg <= '0;
            pass_look_y_reg <= '0;
            pass_frac_reg   <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < PATH_SLOTS; i++)
            begin
                prev_frac_reg[i] <= '0;
                prev_x_reg[i]    <= '0;
                prev_y_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                lookahead_reg <= cfg.data;
            end

            if ((state_reg == ST_FRAC) && frac_gt)
            begin
                pass_frac_reg <= frac_calc;
            end

            if ((state_reg == ST_MUL_WAIT) && mul_done && (op_reg == OP_ALX))
            begin
                pass_look_x_reg <= along_val;
            end

            if ((state_reg == ST_MUL_WAIT) && mul_done && (op_reg == OP_ALY))
            begin
                pass_look_y_reg <= along_val;
                pass_hit_reg    <= 1'b1;
            end

            // load a new beat, or drop the current one once taken
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (pass_hit_reg)
                begin
                    prev_frac_reg[slot_reg] <= pass_frac_reg;
                    prev_x_reg[slot_reg]    <= pass_look_x_reg;
                    prev_y_reg[slot_reg]    <= pass_look_y_reg;
                end
                // clear the pass for the next search
                pass_hit_reg    <= 1'b0;
                pass_look_x_reg <= '0;
                pass_look_y_reg <= '0;
                pass_frac_reg   <= '0;
            end
            else if (look_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (pass_hit_reg)
            begin
                out_data_reg.look_x     <= pass_look_x_reg;
                out_data_reg.look_y     <= pass_look_y_reg;
                out_data_reg.frac_index <= pass_frac_reg;
                out_data_reg.found_new  <= 1'b1;
            end
            else
            begin
                // hold the previous point of the slot
                out_data_reg.look_x     <= prev_x_reg[slot_reg];
                out_data_reg.look_y     <= prev_y_reg[slot_reg];
                out_data_reg.frac_index <= prev_frac_reg[slot_reg];
                out_data_reg.found_new  <= 1'b0;
            end
        end
    end

    assign look_out.valid = out_valid_reg;
    assign look_out.data  = out_data_reg;

`ifndef SYNTHESIS
    // a pass hit is only ever recorded at the end of the second along-track product
    a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pass_hit_reg) |-> ($past(state_reg) == ST_MUL_WAIT)
                                && ($past(op_reg) == OP_ALY))
        else $error("pass hit set outside the along-track step");

    // the long division keeps its partial remainder below a
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_rem_reg < {1'b0, a_reg}))
        else $error("division remainder out of range");

    // a held hit always lies strictly ahead of index zero
    a_hit_frac: assert property (@(posedge clk) disable iff (!rst_n)
        pass_hit_reg |-> (pass_frac_reg != '0))
        else $error("pass hit with zero fractional index");

    // no new segment is taken while the multiplier or root unit is running
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_WAIT || state_reg == ST_SQRT_WAIT) |-> !seg_in.ready)
        else $error("input ready during arithmetic");
`endif

endmodule

`default_nettype wire
